// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

  localparam int WINDOW_DEFAULT       = 64;
  localparam int SAMPLE_WIDTH_DEFAULT = 16;
  localparam int POS_WIDTH            = 32;
  localparam int CFG_WIDTH            = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_SHIFT,
    OP_INSERT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_INSERT
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     full;
  } cell_ctrl_t;

endpackage

// ===== rtl/swm_cell.sv =====
// One deque entry: holds a candidate, evicts itself, shifts toward the head or appends.
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swm_pkg::cell_ctrl_t               ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]    key,
  input  logic [swm_pkg::POS_WIDTH-1:0]     key_pos,
  input  logic                              left_keep,
  input  logic                              right_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]    right_value,
  input  logic [swm_pkg::POS_WIDTH-1:0]     right_pos,
  output logic                              valid,
  output logic signed [SAMPLE_WIDTH-1:0]    value,
  output logic [swm_pkg::POS_WIDTH-1:0]     pos,
  output logic                              keep
);
  import swm_pkg::*;

  logic take_right;
  logic take_new;

  assign keep       = valid && (value > key);
  assign take_right = (ctrl.op == OP_SHIFT) || ((ctrl.op == OP_INSERT) && ctrl.full);
  assign take_new   = (ctrl.op == OP_INSERT) && !ctrl.full && !keep && left_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_CLEAR:  valid <= 1'b0;
        OP_SHIFT:  valid <= right_valid;
        OP_INSERT: valid <= ctrl.full ? right_valid : (keep || left_keep);
        default:   valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_right) begin
      value <= right_value;
      pos   <= right_pos;
    end else if (take_new) begin
      value <= key;
      pos   <= key_pos;
    end
  end

endmodule

// ===== rtl/sliding_window_maximum_top.sv =====
// Sliding window maximum over a sample stream, built on a row of deque cells.
//
//   channel   direction  signals                               content
//   s_axis    in         tvalid tready tdata tuser             sample, first flag
//   m_axis    out        tvalid tready tdata                   window_max, window_end
//   cfg       in         cfg_we cfg_wdata                      window_size
//
// An item passes through accept, one head-expiry check per candidate that leaves the window
// at the head plus a final check that finds none, then evict-and-append in all cells.
// rst is synchronous; it empties the deque, zeroes the position and sets window_size to 3.
// The append cycle waits while a finished result is still held in the output register.
module sliding_window_maximum_top #(
  parameter int WINDOW       = swm_pkg::WINDOW_DEFAULT,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT,
  localparam int IN_BYTES_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_BYTES_W = ((SAMPLE_WIDTH + swm_pkg::POS_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]  cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_BYTES_W-1:0]          s_axis_tdata,   // sample
  input  logic [0:0]                     s_axis_tuser,   // first
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_BYTES_W-1:0]         m_axis_tdata    // window_max, window_end
);
  import swm_pkg::*;

  state_t                         state;
  state_t                         state_next;
  logic [CFG_WIDTH-1:0]           window_size;
  logic [CFG_WIDTH-1:0]           k;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [POS_WIDTH-1:0]           position;
  logic                           window_full;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic [POS_WIDTH-1:0]           window_end;
  cell_ctrl_t                     ctrl;
  logic                           s_fire;
  logic                           expire;
  logic                           stall;
  logic                           emit;
  logic                           insert_go;
  logic signed [SAMPLE_WIDTH-1:0] head_value;

  logic                           c_valid [WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] c_value [WINDOW];
  logic [POS_WIDTH-1:0]           c_pos   [WINDOW];
  logic                           c_keep  [WINDOW];
  logic                           r_valid [WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] r_value [WINDOW];
  logic [POS_WIDTH-1:0]           r_pos   [WINDOW];
  logic                           l_keep  [WINDOW];

  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (window_size == '0) begin
      k = CFG_WIDTH'(1);
    end else if (32'(window_size) > 32'(WINDOW)) begin
      k = CFG_WIDTH'(WINDOW);
    end else begin
      k = window_size;
    end
  end

  assign expire    = c_valid[0] && ((position - c_pos[0]) >= POS_WIDTH'(k));
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign insert_go = (state == ST_INSERT) && !stall;
  assign emit      = window_full || (({1'b0, position} + 33'd1) >= 33'(k));

  always_comb begin
    case (state)
      ST_IDLE:   state_next = s_fire ? ST_EXPIRE : ST_IDLE;
      ST_EXPIRE: state_next = expire ? ST_EXPIRE : ST_INSERT;
      ST_INSERT: state_next = stall ? ST_INSERT : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.full     = c_keep[WINDOW-1];
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.op       = (s_fire && s_axis_tuser[0]) ? OP_CLEAR : OP_HOLD;
      end
      ST_EXPIRE: begin
        ctrl.op = expire ? OP_SHIFT : OP_HOLD;
      end
      ST_INSERT: begin
        ctrl.op = stall ? OP_HOLD : OP_INSERT;
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      window_full <= 1'b0;
    end else if (s_fire && s_axis_tuser[0]) begin
      position    <= '0;
      window_full <= 1'b0;
    end else if (insert_go) begin
      position <= position + POS_WIDTH'(1);
      if (emit) begin
        window_full <= 1'b1;
      end
    end
  end

  // chain wiring: the tail cell's right neighbor is the incoming sample during an append
  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      if (i == WINDOW - 1) begin : g_tail
        assign r_valid[i] = (ctrl.op == OP_INSERT);
        assign r_value[i] = sample;
        assign r_pos[i]   = position;
      end else begin : g_mid
        assign r_valid[i] = c_valid[i+1];
        assign r_value[i] = c_value[i+1];
        assign r_pos[i]   = c_pos[i+1];
      end
      if (i == 0) begin : g_head
        assign l_keep[i] = 1'b1;
      end else begin : g_rest
        assign l_keep[i] = c_keep[i-1];
      end

      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (sample),
        .key_pos    (position),
        .left_keep  (l_keep[i]),
        .right_valid(r_valid[i]),
        .right_value(r_value[i]),
        .right_pos  (r_pos[i]),
        .valid      (c_valid[i]),
        .value      (c_value[i]),
        .pos        (c_pos[i]),
        .keep       (c_keep[i])
      );
    end
  endgenerate

  always_comb begin
    if (!c_keep[0]) begin
      head_value = sample;
    end else if (ctrl.full) begin
      head_value = r_value[0];
    end else begin
      head_value = c_value[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (insert_go && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (insert_go && emit) begin
      window_max <= head_value;
      window_end <= position;
    end
  end

  always_comb begin
    m_axis_tdata                                       = '0;
    m_axis_tdata[SAMPLE_WIDTH-1:0]                     = window_max;
    m_axis_tdata[SAMPLE_WIDTH+POS_WIDTH-1:SAMPLE_WIDTH] = window_end;
  end

endmodule
